// ===== rtl/apf_pkg.sv =====
// ---------------------------------------------------------------------------
// apf_pkg: shared types and constants for the articulation point finder
// Action codes and the result cap.
// ---------------------------------------------------------------------------
package apf_pkg;
	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_RUN   = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	localparam int RESULT_CAP = 32;
endpackage

// ===== rtl/articulation_point_finder_unit.sv =====
// ---------------------------------------------------------------------------
// articulation_point_finder_unit: cut vertices of an undirected graph
// Adjacency matrix load, iterative depth-first search, ordered result stream.
// ---------------------------------------------------------------------------
// channel | signals                                   | role
// in      | in_valid/in_ready, action, vertex_a/b,    | edge add, run, clear
//         | start_vertex                              |
// out     | out_valid/out_ready, cut_vertex,found,last| cut vertices of a run
// cfg     | cfg_we, cfg_wdata                         | vertex_count
// Add does a read-modify-write of row a and then of row b (only row a for a self-loop).
// Clear and reset sweep all MAX_VERTICES rows of the matrix, one row a cycle.
// Run does an iterative depth-first search, one scanned neighbor a cycle, then scans
// vertex indices for the result beats, one index a cycle while the output is not
// stalled (one not-found beat when there is no cut vertex); a start outside n answers
// next cycle. Output stalls hold the result register; input waits until the run ends.
// ---------------------------------------------------------------------------
module articulation_point_finder_unit #(
	parameter int MAX_VERTICES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [4:0] vertex_a,
	input  logic [4:0] vertex_b,
	input  logic [4:0] start_vertex,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] cut_vertex,
	output logic       found,
	output logic       last
);
	import apf_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = VW + 1;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_ADD_B, ST_VISIT, ST_TOP, ST_SCAN, ST_FIN, ST_FIN2,
		ST_EMIT, ST_WAIT
	} state_t;

	state_t state_q;
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_q;
	logic [CW-1:0] disc_mem [MAX_VERTICES];
	logic [CW-1:0] low_mem  [MAX_VERTICES];
	logic [VW-1:0] par_mem  [MAX_VERTICES];
	logic [VW-1:0] stk_mem  [MAX_VERTICES];
	logic [CW-1:0] cur_mem  [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] seen_q, haspar_q, cut_q;

	logic [5:0]    vcount_q;
	logic [CW-1:0] n_q, sp_q, time_q, v_q, rc_q, idx_q;
	logic [VW-1:0] u_q, s_q, a_q, b_q;
	logic [CW-1:0] low_u_q;
	logic          any_q;

	logic [CW-1:0] n_c;
	assign n_c = ({1'b0, vcount_q} > 7'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_q);

	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	logic [VW-1:0] vi;
	assign vi = v_q[VW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			vcount_q <= 6'd32;
			idx_q <= '0;
			out_valid <= 1'b0;
			seen_q <= '0; haspar_q <= '0; cut_q <= '0;
			sp_q <= '0; time_q <= '0; rc_q <= '0; any_q <= 1'b0;
		end else begin
			if (cfg_we) vcount_q <= cfg_wdata;
			if (out_valid && out_ready && state_q != ST_EMIT) out_valid <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					adj_mem[idx_q[VW-1:0]] <= '0;
					idx_q <= idx_q + 1'b1;
					if (idx_q == CW'(MAX_VERTICES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_valid && in_ready) begin
					a_q <= VW'(vertex_a); b_q <= VW'(vertex_b);
					unique case (action_t'(action))
						ACT_ADD: if ({2'b0, vertex_a} < 7'(MAX_VERTICES) &&
							{2'b0, vertex_b} < 7'(MAX_VERTICES)) begin
							row_q <= adj_mem[VW'(vertex_a)];
							state_q <= ST_ADD_B;
						end
						ACT_RUN: if (CW'(start_vertex) < n_c) begin
							n_q <= n_c; s_q <= VW'(start_vertex);
							u_q <= VW'(start_vertex);
							seen_q <= '0; haspar_q <= '0; cut_q <= '0;
							sp_q <= '0; time_q <= '0; rc_q <= '0; any_q <= 1'b0;
							state_q <= ST_VISIT;
						end else begin
							out_valid <= 1'b1; cut_vertex <= '0; found <= 1'b0;
							last <= 1'b1;
						end
						ACT_CLEAR: begin idx_q <= '0; state_q <= ST_CLR; end
						default: ;
					endcase
				end
				ST_ADD_B: begin
					// row_q holds row a; write it, then do row b next idle-free step
					adj_mem[a_q] <= row_q | (MAX_VERTICES'(1) << b_q);
					a_q <= b_q; b_q <= a_q;
					row_q <= adj_mem[b_q];
					state_q <= (a_q == b_q) ? ST_IDLE : ST_WAIT;
				end
				ST_WAIT: begin
					adj_mem[a_q] <= row_q | (MAX_VERTICES'(1) << b_q);
					state_q <= ST_IDLE;
				end
				ST_VISIT: begin
					// u_q is the new vertex; its parent is already in par_mem if haspar
					disc_mem[u_q] <= time_q + 1'b1;
					low_mem[u_q] <= time_q + 1'b1;
					cur_mem[u_q] <= '0;
					time_q <= time_q + 1'b1;
					seen_q[u_q] <= 1'b1;
					stk_mem[sp_q[VW-1:0]] <= u_q;
					sp_q <= sp_q + 1'b1;
					state_q <= ST_TOP;
				end
				ST_TOP: begin
					u_q <= stk_mem[VW'(sp_q - 1'b1)];
					state_q <= ST_FIN2;
					idx_q <= '0;
				end
				ST_FIN2: begin
					row_q <= adj_mem[u_q];
					v_q <= cur_mem[u_q];
					low_u_q <= low_mem[u_q];
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (v_q >= n_q) begin
						cur_mem[u_q] <= v_q;
						low_mem[u_q] <= low_u_q;
						sp_q <= sp_q - 1'b1;
						state_q <= ST_FIN;
					end else if (row_q[vi] && !seen_q[vi]) begin
						cur_mem[u_q] <= v_q;
						low_mem[u_q] <= low_u_q;
						if (u_q == s_q) rc_q <= rc_q + 1'b1;
						par_mem[vi] <= u_q; haspar_q[vi] <= 1'b1;
						u_q <= vi;
						state_q <= ST_VISIT;
					end else begin
						if (row_q[vi] && !(haspar_q[u_q] && par_mem[u_q] == vi) &&
							low_u_q > disc_mem[vi])
							low_u_q <= disc_mem[vi];
						v_q <= v_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (haspar_q[u_q]) begin
						if (low_mem[par_mem[u_q]] > low_u_q) low_mem[par_mem[u_q]] <= low_u_q;
						if (par_mem[u_q] != s_q && low_u_q >= disc_mem[par_mem[u_q]])
							cut_q[par_mem[u_q]] <= 1'b1;
					end
					if (sp_q == '0) begin
						if (rc_q > CW'(1)) cut_q[s_q] <= 1'b1;
						idx_q <= '0;
						state_q <= ST_EMIT;
					end else state_q <= ST_TOP;
				end
				ST_EMIT: if (!out_valid || out_ready) begin
					priority if (idx_q >= n_q) begin
						out_valid <= !any_q;
						if (!any_q) begin
							cut_vertex <= '0; found <= 1'b0;
							last <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else if (cut_q[idx_q[VW-1:0]]) begin
						out_valid <= 1'b1;
						cut_vertex <= 5'(idx_q);
						found <= 1'b1;
						any_q <= 1'b1;
						last <= ((cut_q >> (idx_q + 1'b1)) == '0) ||
							(CW'($countones(cut_q & ((MAX_VERTICES'(1) << idx_q) - 1'b1)))
							== CW'(RESULT_CAP - 1));
						cut_q[idx_q[VW-1:0]] <= 1'b0;
						if (((cut_q >> (idx_q + 1'b1)) == '0) ||
							(CW'($countones(cut_q & ((MAX_VERTICES'(1) << idx_q) - 1'b1)))
							== CW'(RESULT_CAP - 1)))
							state_q <= ST_IDLE;
						idx_q <= idx_q + 1'b1;
					end else begin
						out_valid <= 1'b0;
						idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
